@@ hw/rtl/acpu8_pkg.sv @@
// ----------------------------------------------------------------------------
// acpu8_pkg
// Shared types and constants for the 8-bit accumulator processor core:
// transaction payloads, command and opcode codes, controller states and
// the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package acpu8_pkg;

    localparam int          MEM_DEPTH     = 256;
    localparam int          ADDR_W        = $clog2(MEM_DEPTH);
    localparam int          DATA_W        = 8;
    localparam logic [7:0]  STOP_ADDR_RST = 8'hFF;

    // host commands
    typedef enum logic [2:0] {
        CMD_WR_MEM  = 3'd0,
        CMD_RD_MEM  = 3'd1,
        CMD_STEP    = 3'd2,
        CMD_SET_PC  = 3'd3,
        CMD_SET_ACC = 3'd4
    } t_cmd_e;

    // instruction opcodes (upper nibble of the instruction byte)
    typedef enum logic [3:0] {
        OP_NOP = 4'h0,
        OP_STA = 4'h1,
        OP_LDA = 4'h2,
        OP_ADD = 4'h3,
        OP_OR  = 4'h4,
        OP_AND = 4'h5,
        OP_NOT = 4'h6,
        OP_JMP = 4'h8,
        OP_JN  = 4'h9,
        OP_JZ  = 4'hA,
        OP_HLT = 4'hF
    } t_opcode_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR,
        S_RD,
        S_RDCAP,
        S_SETPC,
        S_SETACC,
        S_FETCH,
        S_DECODE,
        S_OPND,
        S_ACT,
        S_EXEC,
        S_RESP
    } t_state_e;

    typedef enum logic [1:0] {
        ASEL_ITEM,
        ASEL_PC,
        ASEL_OPND
    } t_addr_sel_e;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [3:0]        opcode;
        logic [DATA_W-1:0] operand;
        logic [ADDR_W-1:0] program_counter;
        logic [DATA_W-1:0] accumulator;
        logic              zero_flag;
        logic              negative_flag;
        logic              stopped;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic        load;        // latch new item, clear per-command fields
        t_addr_sel_e addr_sel;
        logic        mem_rd;
        logic        mem_wr;
        logic        wr_acc;      // write accumulator instead of item data
        logic        pc_inc;
        logic        pc_set_item;
        logic        pc_jump;
        logic        acc_set_item;
        logic        acc_not;
        logic        acc_alu;
        logic        latch_rd;
        logic        latch_opc;
        logic        latch_opnd;
        logic        set_halt;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_opcode_e rd_opc;    // opcode nibble of the byte just read
        t_opcode_e opc;       // latched opcode
        logic      acc_zero;
        logic      acc_neg;
    } t_dp_status;

endpackage

@@ hw/rtl/accumulator_cpu_8bit_core.sv @@
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit_core
// 8-bit accumulator teaching processor: host commands write/read memory,
// single-step one instruction, or set PC / accumulator.
// ----------------------------------------------------------------------------
// Usage: present a transaction on i_item and pulse i_start while o_busy is
// low; it is taken on that edge. Exactly one result follows per transaction,
// shown on o_result for a single cycle with o_valid high. The receiver cannot
// stall, so it must take the result in that cycle. States per command: write
// S_WR; read S_RD, S_RDCAP; set PC S_SETPC; set accumulator S_SETACC; step
// S_FETCH, S_DECODE, then S_OPND, S_ACT unless NOP, NOT or HLT, then S_EXEC
// for LDA, ADD, OR and AND; unused codes none. All end in S_RESP, which raises
// the strobe; o_busy drops the cycle after the strobe. The single memory port
// with a registered read sets this order: each step walks through opcode
// fetch, operand fetch and a data read or write in turn. Memory is 256 bytes
// and reads zero after reset until a byte is written (per-byte valid flags,
// no clearing pass). The stop address register is written with
// i_cfg_we/i_cfg_wdata and must only change while the core is idle.
// ----------------------------------------------------------------------------
module accumulator_cpu_8bit_core
    import acpu8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_item             i_item,
    output logic              o_busy,
    output logic              o_valid,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata
);

    t_dp_cmd    w_dp_cmd;    // per-cycle datapath controls
    t_dp_status w_dp_status; // decoded opcode and accumulator flags

    // sequencer: steps each transaction through its states and drives the datapath
    acpu8_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_item.cmd),
        .i_status (w_dp_status),
        .o_dp_cmd (w_dp_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    // memory, PC, accumulator, ALU and result fields
    acpu8_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_dp_cmd    (w_dp_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (w_dp_status),
        .o_result    (o_result)
    );

endmodule

@@ hw/rtl/acpu8_ctrl.sv @@
// ----------------------------------------------------------------------------
// acpu8_ctrl
// Sequencer for the accumulator core: walks each transaction through its
// memory accesses and issues one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module acpu8_ctrl
    import acpu8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_cmd,
    input  t_dp_status i_status,
    output t_dp_cmd    o_dp_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    t_state_e r_state;
    t_state_e n_state;
    t_dp_cmd  w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.addr_sel = ASEL_ITEM;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    case (t_cmd_e'(i_cmd))
                        CMD_WR_MEM:  n_state = S_WR;
                        CMD_RD_MEM:  n_state = S_RD;
                        CMD_STEP:    n_state = S_FETCH;
                        CMD_SET_PC:  n_state = S_SETPC;
                        CMD_SET_ACC: n_state = S_SETACC;
                        default:     n_state = S_RESP;
                    endcase
                end
            end
            S_WR: begin
                w_cmd.mem_wr = 1'b1;
                n_state      = S_RESP;
            end
            S_RD: begin
                w_cmd.mem_rd = 1'b1;
                n_state      = S_RDCAP;
            end
            S_RDCAP: begin
                w_cmd.latch_rd = 1'b1;
                n_state        = S_RESP;
            end
            S_SETPC: begin
                w_cmd.pc_set_item = 1'b1;
                n_state           = S_RESP;
            end
            S_SETACC: begin
                w_cmd.acc_set_item = 1'b1;
                n_state            = S_RESP;
            end
            S_FETCH: begin
                w_cmd.addr_sel = ASEL_PC;
                w_cmd.mem_rd   = 1'b1;
                w_cmd.pc_inc   = 1'b1;
                n_state        = S_DECODE;
            end
            S_DECODE: begin
                w_cmd.latch_opc = 1'b1;
                case (i_status.rd_opc)
                    OP_NOP: n_state = S_RESP;
                    OP_NOT: begin
                        w_cmd.acc_not = 1'b1;
                        n_state       = S_RESP;
                    end
                    OP_HLT: begin
                        w_cmd.set_halt = 1'b1;
                        n_state        = S_RESP;
                    end
                    default: begin
                        // all other codes, unknown ones too, take an operand
                        w_cmd.addr_sel = ASEL_PC;
                        w_cmd.mem_rd   = 1'b1;
                        w_cmd.pc_inc   = 1'b1;
                        n_state        = S_OPND;
                    end
                endcase
            end
            S_OPND: begin
                w_cmd.latch_opnd = 1'b1;
                n_state          = S_ACT;
            end
            S_ACT: begin
                w_cmd.addr_sel = ASEL_OPND;
                n_state        = S_RESP;
                case (i_status.opc)
                    OP_STA: begin
                        w_cmd.mem_wr = 1'b1;
                        w_cmd.wr_acc = 1'b1;
                    end
                    OP_LDA, OP_ADD, OP_OR, OP_AND: begin
                        w_cmd.mem_rd = 1'b1;
                        n_state      = S_EXEC;
                    end
                    OP_JMP: w_cmd.pc_jump = 1'b1;
                    OP_JN:  w_cmd.pc_jump = i_status.acc_neg;
                    OP_JZ:  w_cmd.pc_jump = i_status.acc_zero;
                    default: ;
                endcase
            end
            S_EXEC: begin
                w_cmd.acc_alu = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_dp_cmd = w_cmd;
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_RESP);

    // an accepted transaction always makes the core busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted transaction did not raise busy");

    // result strobe lasts one cycle and returns to idle
    a_resp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !o_busy)
        else $error("result strobe not single cycle");

    // operand fetch only follows a decode
    a_opnd_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OPND |-> $past(r_state) == S_DECODE)
        else $error("operand state entered out of order");

endmodule

@@ hw/rtl/acpu8_dpath.sv @@
// ----------------------------------------------------------------------------
// acpu8_dpath
// Datapath: 256x8 memory with per-entry valid bits (unwritten bytes read as
// zero), PC, accumulator, ALU, stop address register and result assembly.
// ----------------------------------------------------------------------------
module acpu8_dpath
    import acpu8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  t_dp_cmd           i_dp_cmd,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    output t_dp_status        o_status,
    output t_result           o_result
);

    logic [DATA_W-1:0]    r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_vld;
    logic [DATA_W-1:0]    r_rdata;
    logic                 r_rvld;

    t_item             r_item;
    logic [ADDR_W-1:0] r_pc;
    logic [DATA_W-1:0] r_acc;
    logic [ADDR_W-1:0] r_stop;
    logic              r_halt;
    logic [DATA_W-1:0] r_rd;
    logic [3:0]        r_opc;
    logic [DATA_W-1:0] r_opnd;

    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_wdata;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] n_acc;

    always_comb begin
        case (i_dp_cmd.addr_sel)
            ASEL_ITEM: w_addr = r_item.address;
            ASEL_PC:   w_addr = r_pc;
            ASEL_OPND: w_addr = r_opnd;
            default:   w_addr = r_item.address;
        endcase
    end

    assign w_wdata = i_dp_cmd.wr_acc ? r_acc : r_item.data;
    assign w_rdata = r_rvld ? r_rdata : '0;

    // memory array, no reset
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.mem_wr) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_comb begin
        case (t_opcode_e'(r_opc))
            OP_LDA:  n_acc = w_rdata;
            OP_ADD:  n_acc = r_acc + w_rdata;
            OP_OR:   n_acc = r_acc | w_rdata;
            OP_AND:  n_acc = r_acc & w_rdata;
            default: n_acc = r_acc;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rvld    <= 1'b0;
            r_pc      <= '0;
            r_acc     <= '0;
            r_stop    <= STOP_ADDR_RST;
            r_halt    <= 1'b0;
        end else begin
            if (i_dp_cmd.mem_wr) begin
                r_mem_vld[w_addr] <= 1'b1;
            end
            r_rvld <= r_mem_vld[w_addr];
            if (i_cfg_we) begin
                r_stop <= i_cfg_wdata;
            end
            if (i_dp_cmd.load) begin
                r_halt <= 1'b0;
            end else if (i_dp_cmd.set_halt) begin
                r_halt <= 1'b1;
            end
            if (i_dp_cmd.pc_inc) begin
                r_pc <= r_pc + 1'b1;
            end else if (i_dp_cmd.pc_set_item) begin
                r_pc <= r_item.address;
            end else if (i_dp_cmd.pc_jump) begin
                r_pc <= r_opnd;
            end
            if (i_dp_cmd.acc_set_item) begin
                r_acc <= r_item.data;
            end else if (i_dp_cmd.acc_not) begin
                r_acc <= ~r_acc;
            end else if (i_dp_cmd.acc_alu) begin
                r_acc <= n_acc;
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_item <= i_item;
            r_rd   <= '0;
            r_opc  <= '0;
            r_opnd <= '0;
        end else begin
            if (i_dp_cmd.latch_rd) begin
                r_rd <= w_rdata;
            end
            if (i_dp_cmd.latch_opc) begin
                r_opc <= w_rdata[DATA_W-1 -: 4];
            end
            if (i_dp_cmd.latch_opnd) begin
                r_opnd <= w_rdata;
            end
        end
    end

    assign o_status.rd_opc   = t_opcode_e'(w_rdata[DATA_W-1 -: 4]);
    assign o_status.opc      = t_opcode_e'(r_opc);
    assign o_status.acc_zero = (r_acc == '0);
    assign o_status.acc_neg  = r_acc[DATA_W-1];

    assign o_result.read_data       = r_rd;
    assign o_result.opcode          = r_opc;
    assign o_result.operand         = r_opnd;
    assign o_result.program_counter = r_pc;
    assign o_result.accumulator     = r_acc;
    assign o_result.zero_flag       = (r_acc == '0);
    assign o_result.negative_flag   = r_acc[DATA_W-1];
    assign o_result.stopped         = r_halt || (r_pc >= r_stop);

    // a written byte is marked valid
    a_wr_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.mem_wr |=> r_mem_vld[$past(w_addr)])
        else $error("memory write did not set valid bit");

    // PC increments wrap by one
    a_pc_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.pc_inc |=> r_pc == $past(r_pc) + 1'b1)
        else $error("pc increment wrong");

    // new transaction starts with clean per-command fields
    a_load_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.load |=> r_rd == '0 && r_opc == '0 && r_opnd == '0 && !r_halt)
        else $error("per-command fields not cleared");

endmodule
